// ===== rtl/integer_nearest_neighbor_scaler_macros.svh =====
// assertion helpers for the scaler
`ifndef INTEGER_NEAREST_NEIGHBOR_SCALER_MACROS_SVH
`define INTEGER_NEAREST_NEIGHBOR_SCALER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define INNS_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("scaler check failed");

// next-cycle implication, disabled while in reset
`define INNS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("scaler check failed");

`endif

// ===== rtl/inns_pkg.sv =====
`default_nettype none

package inns_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_CHANNEL_BITS = 16;
    localparam int DEF_MAX_FACTOR   = 16;

    // fixed port field widths
    localparam int PIX_BITS       = 16;
    localparam int FACTOR_BITS    = 5;
    localparam int ROW_WIDTH_BITS = 13;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = ROW_WIDTH_BITS;

    // register reset values
    localparam logic                      RST_SCALE_DOWN = 1'b0;
    localparam logic [FACTOR_BITS-1:0]    RST_FACTOR     = 5'd2;
    localparam logic [ROW_WIDTH_BITS-1:0] RST_ROW_WIDTH  = 13'd640;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCALE_DOWN = 2'd0,
        CFG_FACTOR     = 2'd1,
        CFG_ROW_WIDTH  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_TICK  = 1'b1
    } t_mode;

endpackage

`default_nettype wire

// ===== rtl/integer_nearest_neighbor_scaler.sv =====
// Nearest neighbor integer scaler for a raster RGB pixel stream.
// Input channel: i_valid / o_ready carry i_mode and the three channels. A
// pixel transaction (mode 0) while enlarging is sent out factor times and
// written to the line buffer; a repeat tick (mode 1) replays the next stored
// pixel factor times, or nothing when factor is 1. While shrinking only
// pixels on a column and row multiple of factor give one result each.
// Output channel: o_valid / i_ready carry one pixel per transaction with
// o_row_done on the pixel that ends an output row and o_last on the final
// result of each input transaction.
// Configuration: i_cfg_we writes register i_cfg_idx (0 scale_down, 1 factor,
// 2 row_width) with i_cfg_data; write only while the block is idle.
// Pipeline: each result passes the holding stage, then the output register.
// Throughput: one result per cycle while the receiver does not stall, set by
// the single output register that counts down the copies. The next item is
// taken while the last copy of the current one waits on the output.
// A receiver stall holds the output and, once the holding stage is full,
// drops o_ready. Reset clears counters and valid flags and sets config defaults; the pixel
// registers and line buffer are not cleared; the buffer holds nothing valid until a row is written.
`default_nettype none
`include "integer_nearest_neighbor_scaler_macros.svh"

module integer_nearest_neighbor_scaler
    import inns_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
    parameter int MAX_FACTOR   = DEF_MAX_FACTOR
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // input stream
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_mode,
    input  wire logic [PIX_BITS-1:0]       i_red,
    input  wire logic [PIX_BITS-1:0]       i_green,
    input  wire logic [PIX_BITS-1:0]       i_blue,
    // output stream
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [PIX_BITS-1:0]            o_out_red,
    output logic [PIX_BITS-1:0]            o_out_green,
    output logic [PIX_BITS-1:0]            o_out_blue,
    output logic                           o_row_done,
    output logic                           o_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int DW = ((WW > FW) ? WW : FW) + 1;
    localparam int PW = 3 * CHANNEL_BITS;

    // configuration registers
    logic                      r_scale_down;
    logic [FACTOR_BITS-1:0]    r_factor;
    logic [ROW_WIDTH_BITS-1:0] r_row_width;

    // position state
    logic [CW-1:0] r_in_column,   n_in_column;
    logic [CW-1:0] r_replay_col,  n_replay_col;
    logic [FW-1:0] r_col_phase,   n_col_phase;
    logic [FW-1:0] r_row_phase,   n_row_phase;

    // line buffer
    logic [PW-1:0] r_line [MAX_WIDTH];
    logic [PW-1:0] r_mem_q;

    // holding stage
    logic          r_s1_valid;
    logic          r_s1_tick;
    logic [PW-1:0] r_s1_pix;
    logic [FW-1:0] r_s1_cnt;
    logic          r_s1_done;

    // output stage
    logic          r_out_valid;
    logic [PW-1:0] r_out_pix;
    logic [FW-1:0] r_out_rem;
    logic          r_out_done;

    logic [FW-1:0] eff_f, f_m1;
    logic [WW-1:0] eff_w;
    logic [CW-1:0] w_m1;
    logic [CW-1:0] col_c, rc_c;
    logic [FW-1:0] cp_c, rp_c, cp_inc, rp_inc;
    logic [PW-1:0] pix_in;
    logic          in_accept, emit_last, out_free, s1_load;
    logic          wr_en, rd_en, acc_valid, acc_tick, acc_done;
    logic [FW-1:0] acc_cnt;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_down <= RST_SCALE_DOWN;
            r_factor     <= RST_FACTOR;
            r_row_width  <= RST_ROW_WIDTH;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE_DOWN: r_scale_down <= i_cfg_data[0];
                CFG_FACTOR:     r_factor     <= i_cfg_data[FACTOR_BITS-1:0];
                CFG_ROW_WIDTH:  r_row_width  <= i_cfg_data[ROW_WIDTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective factor and width, saturated into range
    always_comb begin
        if (r_factor == '0) begin
            eff_f = FW'(1);
        end else if (32'(r_factor) > 32'(MAX_FACTOR)) begin
            eff_f = FW'(MAX_FACTOR);
        end else begin
            eff_f = FW'(r_factor);
        end
        if (r_row_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_row_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_row_width);
        end
    end

    assign f_m1 = eff_f - 1'b1;
    assign w_m1 = CW'(eff_w - 1'b1);

    // counters left past a new end value are pulled back to it
    assign col_c  = (r_in_column > w_m1) ? w_m1 : r_in_column;
    assign rc_c   = (r_replay_col > w_m1) ? w_m1 : r_replay_col;
    assign cp_c   = (r_col_phase >= eff_f) ? f_m1 : r_col_phase;
    assign rp_c   = (r_row_phase >= eff_f) ? f_m1 : r_row_phase;
    assign cp_inc = cp_c + 1'b1;
    assign rp_inc = rp_c + 1'b1;

    assign pix_in = {i_red[CHANNEL_BITS-1:0], i_green[CHANNEL_BITS-1:0],
                     i_blue[CHANNEL_BITS-1:0]};

    // handshake
    assign emit_last = (r_out_rem == FW'(1));
    assign out_free  = !r_out_valid || (i_ready && emit_last);
    assign s1_load   = r_s1_valid && out_free;
    assign o_ready   = !r_s1_valid || out_free;
    assign in_accept = i_valid && o_ready;

    // per-transaction decisions
    always_comb begin
        n_in_column  = col_c;
        n_replay_col = rc_c;
        n_col_phase  = r_col_phase;
        n_row_phase  = r_row_phase;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        acc_valid    = 1'b0;
        acc_tick     = 1'b0;
        acc_done     = 1'b0;
        acc_cnt      = eff_f;
        if (!r_scale_down) begin
            if (i_mode == MODE_PIXEL) begin
                wr_en     = 1'b1;
                acc_valid = 1'b1;
                acc_done  = (col_c == w_m1);
                if (col_c == '0) begin
                    n_replay_col = '0;
                end
                n_in_column = (col_c == w_m1) ? '0 : col_c + 1'b1;
            end else if (eff_f > FW'(1)) begin
                rd_en        = 1'b1;
                acc_valid    = 1'b1;
                acc_tick     = 1'b1;
                acc_done     = (rc_c == w_m1);
                n_replay_col = (rc_c == w_m1) ? '0 : rc_c + 1'b1;
            end
        end else if (i_mode == MODE_PIXEL) begin
            acc_cnt   = FW'(1);
            acc_valid = (cp_c == '0) && (rp_c == '0);
            acc_done  = (DW'(col_c) + DW'(eff_f)) >= DW'(eff_w);
            if (col_c == w_m1) begin
                n_in_column = '0;
                n_col_phase = '0;
                n_row_phase = (rp_inc >= eff_f) ? '0 : rp_inc;
            end else begin
                n_in_column = col_c + 1'b1;
                n_col_phase = (cp_inc >= eff_f) ? '0 : cp_inc;
                n_row_phase = rp_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_column  <= '0;
            r_replay_col <= '0;
            r_col_phase  <= '0;
            r_row_phase  <= '0;
        end else if (in_accept) begin
            r_in_column  <= n_in_column;
            r_replay_col <= n_replay_col;
            r_col_phase  <= n_col_phase;
            r_row_phase  <= n_row_phase;
        end
    end

    // line buffer write and registered read
    always_ff @(posedge i_clk) begin
        if (in_accept && wr_en) begin
            r_line[col_c] <= pix_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && rd_en) begin
            r_mem_q <= r_line[rc_c];
        end
    end

    // holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= acc_valid;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_tick <= acc_tick;
            r_s1_pix  <= pix_in;
            r_s1_cnt  <= acc_cnt;
            r_s1_done <= acc_done;
        end
    end

    // output stage counts down the copies of one pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_rem   <= '0;
        end else if (s1_load) begin
            r_out_valid <= 1'b1;
            r_out_rem   <= r_s1_cnt;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
            r_out_rem   <= '0;
        end else if (i_ready) begin
            r_out_rem   <= r_out_rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_out_pix  <= r_s1_tick ? r_mem_q : r_s1_pix;
            r_out_done <= r_s1_done;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = PIX_BITS'(r_out_pix[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
    assign o_out_green = PIX_BITS'(r_out_pix[2*CHANNEL_BITS-1:CHANNEL_BITS]);
    assign o_out_blue  = PIX_BITS'(r_out_pix[CHANNEL_BITS-1:0]);
    assign o_last      = emit_last;
    assign o_row_done  = r_out_done && emit_last;

    // checks
    `INNS_ASSERT_SAME(a_rem_nonzero, i_clk, i_rst_n, r_out_valid, r_out_rem != '0)
    `INNS_ASSERT_NEXT(a_rem_step, i_clk, i_rst_n, r_out_valid && i_ready && !emit_last, r_out_valid && (r_out_rem == FW'($past(r_out_rem) - 1'b1)))
    `INNS_ASSERT_SAME(a_shrink_single, i_clk, i_rst_n, r_out_valid && r_scale_down, emit_last)
    `INNS_ASSERT_SAME(a_enlarge_count, i_clk, i_rst_n, r_s1_valid && !r_scale_down, r_s1_cnt == eff_f)

endmodule

`default_nettype wire
